// ----- design/osfq_pkg.sv -----
package osfq_pkg;

   // store size and field widths
   localparam int CAPACITY    = 1024;
   localparam int KEY_W       = 31;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int TREE_LOG    = $clog2(CAPACITY);
   localparam int TREE_LEAVES = 1 << TREE_LOG;
   localparam int TREE_CNT_W  = $clog2(TREE_LOG + 1);

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FOUND    = 2'd1,
      STATUS_NONE     = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   // one leaf of the floor reduction tree: hit flag and masked key
   typedef struct packed {
      logic                    hit;
      logic signed [KEY_W-1:0] key;
   } leaf_type;

endpackage

// ----- design/osfq_cell.sv -----
module osfq_cell
   import osfq_pkg::*;
(
   input  logic                    clock,
   input  logic signed [KEY_W-1:0] cmp_key,
   input  logic                    occupied,
   input  logic                    shift_en,
   input  logic                    left_le,
   input  logic signed [KEY_W-1:0] left_key,
   input  logic                    right_le,
   output logic                    le,
   output logic signed [KEY_W-1:0] key,
   output leaf_type                leaf
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;

   // stored key at or below the broadcast key
   assign le = occupied && (key_ff <= cmp_key);

   // keep, take the new key, or take the left neighbour's key
   always_comb begin
      key_in = key_ff;
      if (shift_en && !le) begin
         key_in = left_le ? cmp_key : left_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // the last cell at or below the bound holds the floor
   always_comb begin
      leaf.hit = le && !right_le;
      leaf.key = leaf.hit ? key_ff : '0;
   end

   assign key = key_ff;

endmodule

// ----- design/osfq_tree.sv -----
module osfq_tree
   import osfq_pkg::*;
(
   input  logic     clock,
   input  leaf_type leaf [CAPACITY],
   output leaf_type root
);

   leaf_type node_ff [1:TREE_LEAVES-1];

   // registered binary or-tree, one level per cycle
   for (genvar j = 1; j < TREE_LEAVES; j++) begin : g_node
      leaf_type lo;
      leaf_type hi;
      if (2 * j >= TREE_LEAVES) begin : g_bottom
         if (2 * j - TREE_LEAVES < CAPACITY) begin : g_lo
            assign lo = leaf[2 * j - TREE_LEAVES];
         end else begin : g_lo_pad
            assign lo = '0;
         end
         if (2 * j + 1 - TREE_LEAVES < CAPACITY) begin : g_hi
            assign hi = leaf[2 * j + 1 - TREE_LEAVES];
         end else begin : g_hi_pad
            assign hi = '0;
         end
      end else begin : g_inner
         assign lo = node_ff[2 * j];
         assign hi = node_ff[2 * j + 1];
      end

      always_ff @(posedge clock) begin
         node_ff[j] <= leaf_type'(lo | hi);
      end
   end

   assign root = node_ff[1];

endmodule

// ----- design/ordered_set_floor_query_unit.sv -----
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------
// request  | in        | req_valid / req_ready | req_func, req_key
// response | out       | rsp_valid / rsp_ready | rsp_status, rsp_value
//
// one item at a time: an insert passes from S_INSERT to S_RESP, and a query
// waits in S_QUERY for the depth of the registered or-tree that gathers the
// floor key from the cell row before it moves to S_RESP.
// reset clears the fill count and control; cell keys are not cleared.
// a stalled response holds its registers and blocks the next request.
module ordered_set_floor_query_unit
   import osfq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [KEY_W-1:0] rsp_value
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_QUERY,
      S_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic signed [KEY_W-1:0] key_ff;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [TREE_CNT_W-1:0]   wait_ff, wait_in;
   status_type              status_ff, status_in;
   logic signed [KEY_W-1:0] value_ff, value_in;

   logic                    full;
   logic                    shift_en;
   logic                    le_row  [CAPACITY];
   logic signed [KEY_W-1:0] key_row [CAPACITY];
   leaf_type                leaf_row [CAPACITY];
   leaf_type                root;

   assign full     = (count_ff == COUNT_W'(CAPACITY));
   assign shift_en = (state_ff == S_INSERT) && !full;

   // row of sorted cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_le;
      logic signed [KEY_W-1:0] left_key;
      logic                    right_le;
      if (i == 0) begin : g_first
         assign left_le  = 1'b1;
         assign left_key = '0;
      end else begin : g_mid
         assign left_le  = le_row[i-1];
         assign left_key = key_row[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_le = 1'b0;
      end else begin : g_next
         assign right_le = le_row[i+1];
      end

      osfq_cell u_cell (
         .clock    (clock),
         .cmp_key  (key_ff),
         .occupied (COUNT_W'(i) < count_ff),
         .shift_en (shift_en),
         .left_le  (left_le),
         .left_key (left_key),
         .right_le (right_le),
         .le       (le_row[i]),
         .key      (key_row[i]),
         .leaf     (leaf_row[i])
      );
   end

   // floor reduction
   osfq_tree u_tree (
      .clock (clock),
      .leaf  (leaf_row),
      .root  (root)
   );

   // sequencing
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      wait_in   = wait_ff;
      status_in = status_ff;
      value_in  = value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_QUERY) ? S_QUERY : S_INSERT;
               wait_in  = '0;
            end
         end
         S_INSERT: begin
            value_in = '0;
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_INSERTED;
               count_in  = count_ff + COUNT_W'(1);
            end
            state_in = S_RESP;
         end
         S_QUERY: begin
            if (wait_ff == TREE_CNT_W'(TREE_LOG)) begin
               status_in = root.hit ? STATUS_FOUND : STATUS_NONE;
               value_in  = root.key;
               state_in  = S_RESP;
            end else begin
               wait_in = wait_ff + TREE_CNT_W'(1);
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wait_ff  <= wait_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      if (req_valid && req_ready) begin
         key_ff <= req_key;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;

endmodule

// ----- design/osfq_checker.sv -----
module osfq_checker
   import osfq_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [1:0]              rsp_status,
   input logic signed [KEY_W-1:0] rsp_value
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value))
      else $error("response changed while stalled");

   // no request taken while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken with response pending");

   // after a request transfer the input closes until its response is out
   a_req_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted before response");

   // exactly one response per request
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response repeated");

   // value is zero unless a floor was found
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_FOUND) |-> rsp_value == '0)
      else $error("nonzero value without a found floor");

endmodule

bind ordered_set_floor_query_unit osfq_checker u_osfq_checker (.*);
